FILE: hdl/ogrc_pkg.sv
// Shared types, codes and defaults for the occupancy grid rectangle claim block.
package ogrc_pkg;

	// Default grid edge length, in cells.
	localparam int GRID_SIZE_DEF = 1024;

	// Largest value that the 11-bit plot extents can carry.
	localparam logic [10:0] PLOT_EXT_MAX = 11'd2047;

	// Request kinds as carried in the kind field.
	typedef enum logic [2:0] {
		KIND_CLAIM = 3'd0,
		KIND_TEST  = 3'd1,
		KIND_FIND  = 3'd2,
		KIND_READ  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	// Which cell the datapath probes: the rectangle walk or one of the four plot walks.
	typedef enum logic [2:0] {
		MODE_RECT,
		MODE_LEFT,
		MODE_RIGHT,
		MODE_UP,
		MODE_DOWN
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GUARD,
		ST_ADDR,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load_item;
		logic  clr_start;
		logic  clr_step;
		logic  set_addr;
		logic  claim_write;
		logic  rect_step;
		logic  find_step;
		logic  hit_set;
		logic  capture_cell;
		logic  load_out;
		logic  out_find;
		mode_t mode;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rect_empty;
		logic guard_ok;
		logic cell_nz;
		logic rect_last;
		logic sweep_last;
	} status_t;

endpackage

FILE: hdl/ogrc_req_if.sv
// Request channel interface: valid, ready and the request item fields.
interface ogrc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [9:0]  col;
	logic [9:0]  row;
	logic [10:0] rect_width;
	logic [10:0] rect_depth;
	logic [7:0]  flag_bits;

	modport source (
		output valid, kind, col, row, rect_width, rect_depth, flag_bits,
		input  ready
	);

	modport sink (
		input  valid, kind, col, row, rect_width, rect_depth, flag_bits,
		output ready
	);
endinterface

FILE: hdl/ogrc_rsp_if.sv
// Result channel interface: valid, ready and the result item fields.
interface ogrc_rsp_if;
	logic        valid;
	logic        ready;
	logic        occupied;
	logic [7:0]  cell_value;
	logic [9:0]  plot_col;
	logic [9:0]  plot_row;
	logic [10:0] plot_width;
	logic [10:0] plot_depth;

	modport source (
		output valid, occupied, cell_value, plot_col, plot_row, plot_width, plot_depth,
		input  ready
	);

	modport sink (
		input  valid, occupied, cell_value, plot_col, plot_row, plot_width, plot_depth,
		output ready
	);
endinterface

FILE: hdl/ogrc_datapath.sv
// Datapath: grid memory, walk coordinates, probe address and result registers.
module ogrc_datapath #(
	parameter int GRID_SIZE = ogrc_pkg::GRID_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ogrc_pkg::cmd_t    cmd,
	output ogrc_pkg::status_t status,
	input  logic [2:0]        kind,
	input  logic [9:0]        col,
	input  logic [9:0]        row,
	input  logic [10:0]       rect_width,
	input  logic [10:0]       rect_depth,
	input  logic [7:0]        flag_bits,
	output logic              occupied,
	output logic [7:0]        cell_value,
	output logic [9:0]        plot_col,
	output logic [9:0]        plot_row,
	output logic [10:0]       plot_width,
	output logic [10:0]       plot_depth
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_SIZE);
	localparam int EW    = CW + 1;
	localparam int SW    = (EW > 11) ? EW + 1 : 12;

	logic [7:0]    cells_q [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] probe_addr;
	logic [CW-1:0] probe_c;
	logic [CW-1:0] probe_r;
	logic          guard_ok;
	logic          we;
	logic [7:0]    wdata;

	logic [CW-1:0] x_q, z_q, x1_q, z1_q, i_q, j_q, c1_q, r1_q;
	logic [EW-1:0] x2_q, z2_q;
	logic [CW-1:0] col_c, row_c, col_end_c, row_end_c;
	logic [7:0]    flags_q;
	logic          hit_q;
	logic [7:0]    cell_q;
	logic [EW-1:0] wdiff, ddiff;

	logic          out_occupied_q;
	logic [7:0]    out_cell_q;
	logic [9:0]    out_col_q;
	logic [9:0]    out_row_q;
	logic [10:0]   out_width_q;
	logic [10:0]   out_depth_q;

	// Clamp a coordinate onto the last column or row.
	function automatic logic [CW-1:0] clamp_c(input logic [SW-1:0] v);
		clamp_c = (v > SW'(GRID_SIZE - 1)) ? CW'(GRID_SIZE - 1) : v[CW-1:0];
	endfunction

	// Clamped start cell and rectangle far corner of the incoming item.
	assign col_c     = clamp_c(SW'(col));
	assign row_c     = clamp_c(SW'(row));
	assign col_end_c = clamp_c(SW'(col) + SW'(rect_width) - SW'(1));
	assign row_end_c = clamp_c(SW'(row) + SW'(rect_depth) - SW'(1));

	// Probe cell for the current walk, and whether the walk may take another step.
	always_comb begin
		probe_c  = i_q;
		probe_r  = j_q;
		guard_ok = 1'b0;
		unique case (cmd.mode)
			ogrc_pkg::MODE_RECT: begin
				probe_c  = i_q;
				probe_r  = j_q;
				guard_ok = 1'b0;
			end
			ogrc_pkg::MODE_LEFT: begin
				probe_c  = x1_q - CW'(1);
				probe_r  = z_q;
				guard_ok = (x1_q != '0);
			end
			ogrc_pkg::MODE_RIGHT: begin
				probe_c  = clamp_c(SW'(x2_q) + SW'(1));
				probe_r  = z_q;
				guard_ok = (x2_q < EW'(GRID_SIZE));
			end
			ogrc_pkg::MODE_UP: begin
				probe_c  = x_q;
				probe_r  = z1_q - CW'(1);
				guard_ok = (z1_q != '0);
			end
			ogrc_pkg::MODE_DOWN: begin
				probe_c  = x_q;
				probe_r  = clamp_c(SW'(z2_q) + SW'(1));
				guard_ok = (z2_q < EW'(GRID_SIZE));
			end
			default: begin
				probe_c  = i_q;
				probe_r  = j_q;
				guard_ok = 1'b0;
			end
		endcase
	end

	// Cells are stored column by column: address is col * GRID_SIZE + row.
	assign probe_addr = AW'(probe_c) * AW'(GRID_SIZE) + AW'(probe_r);

	assign status.guard_ok   = guard_ok;
	assign status.rect_empty = (rect_width == '0) || (rect_depth == '0);
	assign status.cell_nz    = (rdata_q != '0);
	assign status.rect_last  = (i_q == c1_q) && (j_q == r1_q);
	assign status.sweep_last = (addr_q == AW'(DEPTH - 1));

	// Memory address register: loaded from the probe or stepped by the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.clr_start) begin
			addr_q <= '0;
		end else if (cmd.clr_step) begin
			addr_q <= addr_q + AW'(1);
		end else if (cmd.set_addr) begin
			addr_q <= probe_addr;
		end
	end

	// Grid memory: one write and one registered read per cycle.
	assign we    = cmd.claim_write || cmd.clr_step;
	assign wdata = cmd.clr_step ? 8'd0 : (rdata_q | flags_q);

	always_ff @(posedge clk) begin
		if (we) begin
			cells_q[addr_q] <= wdata;
		end
		rdata_q <= cells_q[addr_q];
	end

	// Walk coordinates and per-item result bits.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q     <= col_c;
			z_q     <= row_c;
			x1_q    <= col_c;
			z1_q    <= row_c;
			x2_q    <= EW'(col_c);
			z2_q    <= EW'(row_c);
			i_q     <= col_c;
			j_q     <= row_c;
			c1_q    <= (kind == ogrc_pkg::KIND_READ) ? col_c : col_end_c;
			r1_q    <= (kind == ogrc_pkg::KIND_READ) ? row_c : row_end_c;
			flags_q <= flag_bits;
			hit_q   <= 1'b0;
			cell_q  <= 8'd0;
		end else begin
			if (cmd.rect_step) begin
				if (j_q == r1_q) begin
					j_q <= z_q;
					i_q <= i_q + CW'(1);
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			if (cmd.find_step) begin
				unique case (cmd.mode)
					ogrc_pkg::MODE_LEFT:  x1_q <= x1_q - CW'(1);
					ogrc_pkg::MODE_RIGHT: x2_q <= x2_q + EW'(1);
					ogrc_pkg::MODE_UP:    z1_q <= z1_q - CW'(1);
					ogrc_pkg::MODE_DOWN:  z2_q <= z2_q + EW'(1);
					default: ;
				endcase
			end
			if (cmd.hit_set) begin
				hit_q <= 1'b1;
			end
			if (cmd.capture_cell) begin
				cell_q <= rdata_q;
			end
		end
	end

	// Open extents; they are saturated to the width of the result fields in the output register.
	assign wdiff = x2_q - EW'(x1_q);
	assign ddiff = z2_q - EW'(z1_q);

	// Output register holding the finished result item.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_occupied_q <= hit_q;
			out_cell_q     <= cell_q;
			if (cmd.out_find) begin
				out_col_q   <= 10'(x1_q);
				out_row_q   <= 10'(z1_q);
				out_width_q <= (32'(wdiff) > 32'(ogrc_pkg::PLOT_EXT_MAX)) ?
					ogrc_pkg::PLOT_EXT_MAX : 11'(wdiff);
				out_depth_q <= (32'(ddiff) > 32'(ogrc_pkg::PLOT_EXT_MAX)) ?
					ogrc_pkg::PLOT_EXT_MAX : 11'(ddiff);
			end else begin
				out_col_q   <= 10'd0;
				out_row_q   <= 10'd0;
				out_width_q <= 11'd0;
				out_depth_q <= 11'd0;
			end
		end
	end

	assign occupied   = out_occupied_q;
	assign cell_value = out_cell_q;
	assign plot_col   = out_col_q;
	assign plot_row   = out_row_q;
	assign plot_width = out_width_q;
	assign plot_depth = out_depth_q;

endmodule

FILE: hdl/ogrc_ctrl.sv
// Controller: request sequencing state machine and result valid flag.
module ogrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [2:0]        req_kind,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ogrc_pkg::cmd_t    cmd,
	input  ogrc_pkg::status_t status
);

	ogrc_pkg::state_t state_q, state_d;
	ogrc_pkg::mode_t  mode_q, mode_d;
	ogrc_pkg::kind_t  kind_q, kind_d;
	ogrc_pkg::kind_t  req_kind_e;
	logic             out_valid_q;
	logic             out_free;

	// Order of the plot walks: left, right, up, down.
	function automatic ogrc_pkg::mode_t next_mode(input ogrc_pkg::mode_t m);
		unique case (m)
			ogrc_pkg::MODE_LEFT:  next_mode = ogrc_pkg::MODE_RIGHT;
			ogrc_pkg::MODE_RIGHT: next_mode = ogrc_pkg::MODE_UP;
			default:              next_mode = ogrc_pkg::MODE_DOWN;
		endcase
	endfunction

	assign req_kind_e = ogrc_pkg::kind_t'(req_kind);
	assign out_free   = !out_valid_q || rsp_ready;
	assign req_ready  = (state_q == ogrc_pkg::ST_IDLE);
	assign rsp_valid  = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		kind_d  = kind_q;
		unique case (state_q)
			ogrc_pkg::ST_CLEAR: begin
				if (status.sweep_last) begin
					state_d = (kind_q == ogrc_pkg::KIND_CLEAR) ? ogrc_pkg::ST_DONE :
						ogrc_pkg::ST_IDLE;
				end
			end
			ogrc_pkg::ST_IDLE: begin
				if (req_valid) begin
					kind_d = req_kind_e;
					mode_d = ogrc_pkg::MODE_RECT;
					unique case (req_kind_e)
						ogrc_pkg::KIND_CLAIM, ogrc_pkg::KIND_TEST: begin
							state_d = status.rect_empty ? ogrc_pkg::ST_DONE : ogrc_pkg::ST_ADDR;
						end
						ogrc_pkg::KIND_READ: state_d = ogrc_pkg::ST_ADDR;
						ogrc_pkg::KIND_FIND: begin
							mode_d  = ogrc_pkg::MODE_LEFT;
							state_d = ogrc_pkg::ST_GUARD;
						end
						ogrc_pkg::KIND_CLEAR: state_d = ogrc_pkg::ST_CLEAR;
						default: state_d = ogrc_pkg::ST_DONE;
					endcase
				end
			end
			ogrc_pkg::ST_GUARD: begin
				if (status.guard_ok) begin
					state_d = ogrc_pkg::ST_ADDR;
				end else if (mode_q == ogrc_pkg::MODE_DOWN) begin
					state_d = ogrc_pkg::ST_DONE;
				end else begin
					mode_d = next_mode(mode_q);
				end
			end
			ogrc_pkg::ST_ADDR: state_d = ogrc_pkg::ST_READ;
			ogrc_pkg::ST_READ: state_d = ogrc_pkg::ST_CHECK;
			ogrc_pkg::ST_CHECK: begin
				if (mode_q == ogrc_pkg::MODE_RECT) begin
					unique case (kind_q)
						ogrc_pkg::KIND_TEST: begin
							state_d = (status.cell_nz || status.rect_last) ? ogrc_pkg::ST_DONE :
								ogrc_pkg::ST_ADDR;
						end
						ogrc_pkg::KIND_CLAIM: begin
							state_d = status.rect_last ? ogrc_pkg::ST_DONE : ogrc_pkg::ST_ADDR;
						end
						default: state_d = ogrc_pkg::ST_DONE;
					endcase
				end else if (!status.cell_nz) begin
					state_d = ogrc_pkg::ST_GUARD;
				end else if (mode_q == ogrc_pkg::MODE_DOWN) begin
					state_d = ogrc_pkg::ST_DONE;
				end else begin
					mode_d  = next_mode(mode_q);
					state_d = ogrc_pkg::ST_GUARD;
				end
			end
			ogrc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ogrc_pkg::ST_IDLE;
				end
			end
			default: state_d = ogrc_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd          = '0;
		cmd.mode     = mode_q;
		cmd.out_find = (kind_q == ogrc_pkg::KIND_FIND);
		unique case (state_q)
			ogrc_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			ogrc_pkg::ST_IDLE: begin
				cmd.load_item = req_valid;
				cmd.clr_start = req_valid && (req_kind_e == ogrc_pkg::KIND_CLEAR);
			end
			ogrc_pkg::ST_GUARD: ;
			ogrc_pkg::ST_ADDR:  cmd.set_addr = 1'b1;
			ogrc_pkg::ST_READ:  ;
			ogrc_pkg::ST_CHECK: begin
				if (mode_q == ogrc_pkg::MODE_RECT) begin
					unique case (kind_q)
						ogrc_pkg::KIND_TEST: begin
							cmd.hit_set   = status.cell_nz;
							cmd.rect_step = !status.cell_nz && !status.rect_last;
						end
						ogrc_pkg::KIND_CLAIM: begin
							cmd.claim_write = 1'b1;
							cmd.rect_step   = !status.rect_last;
						end
						default: cmd.capture_cell = 1'b1;
					endcase
				end else begin
					cmd.find_step = !status.cell_nz;
				end
			end
			ogrc_pkg::ST_DONE: cmd.load_out = out_free;
			default: ;
		endcase
	end

	// State, walk mode and request kind registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ogrc_pkg::ST_CLEAR;
			mode_q  <= ogrc_pkg::MODE_RECT;
			kind_q  <= ogrc_pkg::KIND_CLAIM;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			kind_q  <= kind_d;
		end
	end

	// Result valid flag: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/occupancy_grid_rect_claim_core.sv
// Top level of the occupancy grid rectangle claim block.
// The block holds a GRID_SIZE x GRID_SIZE grid of 8-bit cells in one memory with one write
// port and one registered read port, and serves one request at a time. Every cell visit
// passes through the address register, the memory read and the check or read-modify-write.
// A claim or a test visits each cell of the clamped rectangle (a test stops at the first
// nonzero cell), a read visits a single cell, and a find-plot makes an edge check before
// each cell it probes and one more for each direction that runs into the grid edge.
// A clear sweeps the memory one cell per cycle; the same sweep runs after reset, and no
// request is accepted until it has finished. A finished result waits in an output
// register, and the next request is accepted while it waits.
module occupancy_grid_rect_claim_core #(
	parameter int GRID_SIZE = ogrc_pkg::GRID_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ogrc_req_if.sink   req,
	ogrc_rsp_if.source rsp
);

	ogrc_pkg::cmd_t    cmd;
	ogrc_pkg::status_t status;

	// Request sequencing.
	ogrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Grid memory and walk datapath.
	ogrc_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (req.kind),
		.col        (req.col),
		.row        (req.row),
		.rect_width (req.rect_width),
		.rect_depth (req.rect_depth),
		.flag_bits  (req.flag_bits),
		.occupied   (rsp.occupied),
		.cell_value (rsp.cell_value),
		.plot_col   (rsp.plot_col),
		.plot_row   (rsp.plot_row),
		.plot_width (rsp.plot_width),
		.plot_depth (rsp.plot_depth)
	);

	// No request is taken while the grid memory is being written.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.claim_write || cmd.clr_step) |-> !req.ready)
		else $error("request accepted during a grid write");

	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("pending result overwritten");

	// After an item is accepted the block is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> !req.ready)
		else $error("second item accepted while one is in progress");

endmodule
